@@ rtl/typed_io_register_file_with_stack_unit_macros.svh @@
// Assertion macros for the typed I/O register file with stack unit.
// Users must have clk and arst_n in scope; checks are off while reset is low.
`ifndef TYPED_IO_REGISTER_FILE_WITH_STACK_UNIT_MACROS_SVH
`define TYPED_IO_REGISTER_FILE_WITH_STACK_UNIT_MACROS_SVH

// Same-cycle implication.
`define TIORF_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tiorf: same-cycle check failed");

// Next-cycle implication.
`define TIORF_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tiorf: next-cycle check failed");

`endif

@@ rtl/tiorf_pkg.sv @@
// Shared constants, codes and types for the typed I/O register file with stack unit.
// No dependencies.
package tiorf_pkg;

	// Sizes of the stores.
	localparam int REG_COUNT   = 256;
	localparam int MEM_BYTES   = 8192;
	localparam int TIMER_COUNT = 6;

	localparam int RF_AW = $clog2(REG_COUNT);
	localparam int DM_AW = $clog2(MEM_BYTES);
	localparam int TL_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

	// Index arithmetic width: holds the largest register index plus one.
	localparam int IDX_W = 11;
	// Stack compare width: holds a 16-bit pointer and the data memory size.
	localparam int SP_CW = 17;

	// Reset clearing pass covers the larger of the two memories.
	localparam int CLR_DEPTH = (REG_COUNT > MEM_BYTES) ? REG_COUNT : MEM_BYTES;
	localparam int CLR_W     = $clog2(CLR_DEPTH);

	localparam logic [IDX_W-1:0] REG_LIM    = IDX_W'(REG_COUNT);
	localparam logic [SP_CW-1:0] MEM_LIM    = SP_CW'(MEM_BYTES);
	localparam logic [2:0]       TIMER_LIM  = 3'(TIMER_COUNT);
	localparam logic [CLR_W-1:0] CLR_LAST   = CLR_W'(CLR_DEPTH - 1);
	localparam logic [CLR_W:0]   CLR_RF_LIM = (CLR_W + 1)'(REG_COUNT);
	localparam logic [CLR_W:0]   CLR_DM_LIM = (CLR_W + 1)'(MEM_BYTES);

	localparam logic [7:0]  BYTE_ONES     = 8'hFF;
	localparam logic [13:0] SP_NARROW_MAX = 14'd256;

	// Configuration port.
	localparam int CFG_IW = 2;
	localparam int CFG_DW = 14;
	localparam logic [CFG_IW-1:0] CFG_STACK_IDX = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_RAM_START = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_RAM_SIZE  = 2'd2;

	localparam logic [7:0]  RST_STACK_IDX = 8'd93;
	localparam logic [13:0] RST_RAM_START = 14'd256;
	localparam logic [13:0] RST_RAM_SIZE  = 14'd2048;

	// Access kinds.
	localparam logic [2:0] K_READ   = 3'd0;
	localparam logic [2:0] K_WRITE  = 3'd1;
	localparam logic [2:0] K_MASKED = 3'd2;
	localparam logic [2:0] K_PUSH   = 3'd3;
	localparam logic [2:0] K_POP    = 3'd4;

	// Register types.
	localparam logic [2:0] T_RSVD  = 3'd0;
	localparam logic [2:0] T_PLAIN = 3'd1;
	localparam logic [2:0] T_CLR   = 3'd2;
	localparam logic [2:0] T_EEP   = 3'd3;
	localparam logic [2:0] T_SPM   = 3'd4;
	localparam logic [2:0] T_TCTRL = 3'd5;
	localparam logic [2:0] T_TLOW  = 3'd6;
	localparam logic [2:0] T_THIGH = 3'd7;

	// Event codes.
	localparam logic [2:0] EV_NONE   = 3'd0;
	localparam logic [2:0] EV_FAULT  = 3'd1;
	localparam logic [2:0] EV_TIMER  = 3'd2;
	localparam logic [2:0] EV_EEPROM = 3'd3;
	localparam logic [2:0] EV_SPM    = 3'd4;

	// Configuration as seen by the sequencer.
	typedef struct packed {
		logic [7:0]  stack_idx;
		logic [14:0] limit;
		logic        sp_wide;
	} cfg_t;

endpackage

@@ rtl/tiorf_ram.sv @@
// Generic simple dual-port RAM with one registered read port.
// No dependencies.
module tiorf_ram #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port; the data holds until the next enabled read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/tiorf_cfg.sv @@
// Configuration registers and the stack limit and width derived from them.
// Depends on tiorf_pkg.
module tiorf_cfg
	import tiorf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data,
	output cfg_t              cfg
);

	logic [7:0]  stack_idx_q;
	logic [13:0] ram_start_q;
	logic [13:0] ram_size_q;
	logic [14:0] limit_q;
	logic        sp_wide_q;

	assign cfg_ready = 1'b1;

	// Register writes, plus the derived limit and pointer width in the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_idx_q <= RST_STACK_IDX;
			ram_start_q <= RST_RAM_START;
			ram_size_q  <= RST_RAM_SIZE;
			limit_q     <= {1'b0, RST_RAM_START} + {1'b0, RST_RAM_SIZE};
			sp_wide_q   <= 1'b1;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_STACK_IDX: stack_idx_q <= cfg_data[7:0];
					CFG_RAM_START: ram_start_q <= cfg_data;
					CFG_RAM_SIZE:  ram_size_q  <= cfg_data;
					default: ;
				endcase
			end
			limit_q   <= {1'b0, ram_start_q} + {1'b0, ram_size_q};
			sp_wide_q <= ram_size_q > SP_NARROW_MAX;
		end
	end

	assign cfg.stack_idx = stack_idx_q;
	assign cfg.limit     = limit_q;
	assign cfg.sp_wide   = sp_wide_q;

endmodule

@@ rtl/typed_io_register_file_with_stack_unit.sv @@
// Typed I/O register file with stack push and pop; uses tiorf_pkg, tiorf_cfg, tiorf_ram.
// Steps from accept to out_valid: low read, high read, execute, then the result load, which
// waits for a free output. The next request is taken at the earliest in the cycle the
// previous result is loaded, as the register file ports serve two reads and two writes.
// Reset: a clearing pass over max(REG_COUNT, MEM_BYTES) = 8192 entries zeroes both memories;
// in_ready stays low during it while configuration writes are taken as usual.
`include "typed_io_register_file_with_stack_unit_macros.svh"

module typed_io_register_file_with_stack_unit
	import tiorf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [2:0]        kind,
	input  logic [7:0]        reg_addr,
	input  logic [2:0]        reg_type,
	input  logic [2:0]        timer_sel,
	input  logic [7:0]        data_in,
	input  logic [7:0]        bit_mask,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        read_data,
	output logic [2:0]        event_res,
	output logic [2:0]        event_timer,
	output logic [7:0]        fwd_value,
	output logic [7:0]        fwd_mask,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_RD2, ST_EXEC, ST_WR2} state_t;

	state_t           state_q;
	cfg_t             cfg;
	logic [CLR_W-1:0] clr_cnt_q;

	// Request registers.
	logic [2:0]       kind_q;
	logic [2:0]       type_q;
	logic [2:0]       tsel_q;
	logic [7:0]       din_q;
	logic [7:0]       msk_q;
	logic [IDX_W-1:0] base_q;
	logic [7:0]       lo_q;

	// Execute results held for the final step.
	logic [7:0] res_rd_q;
	logic [2:0] res_ev_q;
	logic [2:0] res_tm_q;
	logic [7:0] res_fv_q;
	logic [7:0] res_fm_q;
	logic       res_pop_q;
	logic       wr2_en_q;
	logic [7:0] wr2_data_q;

	// Output registers.
	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic [2:0] event_res_q;
	logic [2:0] event_timer_q;
	logic [7:0] fwd_value_q;
	logic [7:0] fwd_mask_q;

	logic [7:0] timer_latch_q [TIMER_COUNT];

	logic             accept;
	logic             out_free;
	logic             stack_in;
	logic [2:0]       eff_type;
	logic [IDX_W-1:0] base_in;
	logic [IDX_W-1:0] nxt_idx;
	logic             nxt_ok;
	logic             base_ok;

	// Register file port signals.
	logic             rf_we;
	logic [RF_AW-1:0] rf_waddr;
	logic [7:0]       rf_wdata;
	logic             rf_re;
	logic [RF_AW-1:0] rf_raddr;
	logic [7:0]       rf_ram_rd;
	logic [7:0]       rf_rd;
	logic             fwd_hit_q;
	logic [7:0]       fwd_data_q;

	// Data memory port signals.
	logic             dm_we;
	logic [DM_AW-1:0] dm_waddr;
	logic [7:0]       dm_wdata;
	logic             dm_re;
	logic [DM_AW-1:0] dm_raddr;
	logic [7:0]       dm_rdata;

	// Execute datapath.
	logic [7:0]  nb;
	logic [7:0]  lat;
	logic [15:0] sp;
	logic [15:0] sp_dec;
	logic [15:0] sp_inc;
	logic [15:0] nsp_push;
	logic [15:0] nsp_pop;
	logic        push_ok;
	logic        pop_ok;
	logic [7:0]  val;
	logic [7:0]  mask_f;
	logic [7:0]  x_rd;
	logic [2:0]  x_ev;
	logic [2:0]  x_tm;
	logic [7:0]  x_fv;
	logic [7:0]  x_fm;
	logic        x_pop;
	logic        x_w1_en;
	logic [7:0]  x_w1_data;
	logic        x_w2_en;
	logic [7:0]  x_w2_data;
	logic        x_dm_we;
	logic        latch_we;
	logic [7:0]  latch_data;
	logic        clr_rf_en;
	logic        clr_dm_en;

	tiorf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake.
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) || ((state_q == ST_WR2) && out_free);
	assign accept   = in_valid && in_ready;

	// Decode of the incoming request: out-of-range registers and timers act as reserved.
	always_comb begin
		stack_in = (kind == K_PUSH) || (kind == K_POP);
		base_in  = stack_in ? IDX_W'(cfg.stack_idx) : IDX_W'(reg_addr);
		eff_type = reg_type;
		if (IDX_W'(reg_addr) >= REG_LIM) begin
			eff_type = T_RSVD;
		end else if ((reg_type inside {T_TCTRL, T_TLOW, T_THIGH}) && (timer_sel >= TIMER_LIM)) begin
			eff_type = T_RSVD;
		end
	end

	assign nxt_idx = base_q + IDX_W'(1);
	assign nxt_ok  = nxt_idx < REG_LIM;
	assign base_ok = base_q < REG_LIM;

	// Register file read: the addressed byte at accept, the next byte in the cycle after.
	assign rf_re    = accept || (state_q == ST_RD2);
	assign rf_raddr = (state_q == ST_RD2) ? nxt_idx[RF_AW-1:0] : base_in[RF_AW-1:0];

	// Forward a write that lands on the entry read in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q  <= 1'b0;
			fwd_data_q <= '0;
		end else if (rf_re) begin
			fwd_hit_q  <= rf_we && (rf_waddr == rf_raddr);
			fwd_data_q <= rf_wdata;
		end
	end

	assign rf_rd = fwd_hit_q ? fwd_data_q : rf_ram_rd;

	// Stack pointer and its bounds, timer latch read, merged write value and mask.
	always_comb begin
		nb       = nxt_ok ? rf_rd : 8'h00;
		lat      = timer_latch_q[tsel_q[TL_W-1:0]];
		sp       = {cfg.sp_wide ? nb : 8'h00, base_ok ? lo_q : 8'h00};
		sp_dec   = sp - 16'd1;
		sp_inc   = sp + 16'd1;
		nsp_push = cfg.sp_wide ? sp_dec : {8'h00, sp_dec[7:0]};
		nsp_pop  = cfg.sp_wide ? sp_inc : {8'h00, sp_inc[7:0]};
		push_ok  = (SP_CW'(sp) < SP_CW'(cfg.limit)) && (SP_CW'(sp) < MEM_LIM);
		pop_ok   = (SP_CW'(sp) < SP_CW'(cfg.limit)) && (SP_CW'(nsp_pop) < MEM_LIM);
		if ((kind_q == K_MASKED) && !(type_q inside {T_EEP, T_SPM})) begin
			val = (lo_q & ~msk_q) | (din_q & msk_q);
		end else begin
			val = din_q;
		end
		mask_f = (kind_q == K_MASKED) ? msk_q : BYTE_ONES;
	end

	// Execute step: result fields, register writes, latch and data memory effects.
	always_comb begin
		x_rd       = 8'h00;
		x_ev       = EV_NONE;
		x_tm       = 3'd0;
		x_fv       = 8'h00;
		x_fm       = 8'h00;
		x_pop      = 1'b0;
		x_w1_en    = 1'b0;
		x_w1_data  = 8'h00;
		x_w2_en    = 1'b0;
		x_w2_data  = 8'h00;
		x_dm_we    = 1'b0;
		latch_we   = 1'b0;
		latch_data = 8'h00;
		if (state_q == ST_EXEC) begin
			case (kind_q)
				K_READ: begin
					case (type_q)
						T_RSVD:  x_rd = BYTE_ONES;
						T_THIGH: x_rd = lat;
						T_TLOW: begin
							x_rd       = lo_q;
							latch_we   = 1'b1;
							latch_data = nb;
						end
						default: x_rd = lo_q;
					endcase
				end
				K_WRITE, K_MASKED: begin
					case (type_q)
						T_PLAIN: begin
							x_w1_en   = 1'b1;
							x_w1_data = val;
						end
						T_CLR: begin
							x_w1_en   = 1'b1;
							x_w1_data = lo_q & ~val;
						end
						T_EEP: begin
							x_ev = EV_EEPROM;
							x_fv = val;
							x_fm = mask_f;
						end
						T_SPM: begin
							x_ev = EV_SPM;
							x_fv = val;
							x_fm = mask_f;
						end
						T_TCTRL: begin
							x_w1_en   = 1'b1;
							x_w1_data = val;
							x_ev      = EV_TIMER;
							x_tm      = tsel_q;
						end
						T_TLOW: begin
							x_w1_en   = 1'b1;
							x_w1_data = val;
							x_w2_en   = nxt_ok;
							x_w2_data = lat;
							x_ev      = EV_TIMER;
							x_tm      = tsel_q;
						end
						T_THIGH: begin
							latch_we   = 1'b1;
							latch_data = val;
						end
						default: ;
					endcase
				end
				K_PUSH: begin
					if (push_ok) begin
						x_dm_we   = 1'b1;
						x_w1_en   = base_ok;
						x_w1_data = nsp_push[7:0];
						x_w2_en   = cfg.sp_wide && nxt_ok;
						x_w2_data = nsp_push[15:8];
					end else begin
						x_ev = EV_FAULT;
					end
				end
				K_POP: begin
					if (pop_ok) begin
						x_pop     = 1'b1;
						x_w1_en   = base_ok;
						x_w1_data = nsp_pop[7:0];
						x_w2_en   = cfg.sp_wide && nxt_ok;
						x_w2_data = nsp_pop[15:8];
					end else begin
						x_ev = EV_FAULT;
					end
				end
				default: ;
			endcase
		end
	end

	// Register file write port: clearing pass, first write in execute, second in the last step.
	assign clr_rf_en = {1'b0, clr_cnt_q} < CLR_RF_LIM;
	assign clr_dm_en = {1'b0, clr_cnt_q} < CLR_DM_LIM;

	always_comb begin
		rf_we    = 1'b0;
		rf_waddr = base_q[RF_AW-1:0];
		rf_wdata = 8'h00;
		case (state_q)
			ST_CLEAR: begin
				rf_we    = clr_rf_en;
				rf_waddr = clr_cnt_q[RF_AW-1:0];
			end
			ST_EXEC: begin
				rf_we    = x_w1_en;
				rf_wdata = x_w1_data;
			end
			ST_WR2: begin
				rf_we    = wr2_en_q && out_free;
				rf_waddr = nxt_idx[RF_AW-1:0];
				rf_wdata = wr2_data_q;
			end
			default: ;
		endcase
	end

	tiorf_ram #(
		.DEPTH (REG_COUNT),
		.WIDTH (8)
	) u_rf (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (rf_re),
		.raddr (rf_raddr),
		.rdata (rf_ram_rd)
	);

	// Data memory: zeroed by the clearing pass, written by push, read by pop.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			dm_we    = clr_dm_en;
			dm_waddr = clr_cnt_q[DM_AW-1:0];
			dm_wdata = 8'h00;
		end else begin
			dm_we    = x_dm_we;
			dm_waddr = sp[DM_AW-1:0];
			dm_wdata = din_q;
		end
	end

	assign dm_re    = x_pop;
	assign dm_raddr = nsp_pop[DM_AW-1:0];

	tiorf_ram #(
		.DEPTH (MEM_BYTES),
		.WIDTH (8)
	) u_dm (
		.clk   (clk),
		.we    (dm_we),
		.waddr (dm_waddr),
		.wdata (dm_wdata),
		.re    (dm_re),
		.raddr (dm_raddr),
		.rdata (dm_rdata)
	);

	// Timer high-byte latches.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TIMER_COUNT; i++) begin
				timer_latch_q[i] <= 8'h00;
			end
		end else if (latch_we) begin
			timer_latch_q[tsel_q[TL_W-1:0]] <= latch_data;
		end
	end

	// Sequencer with request, result and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_cnt_q     <= '0;
			kind_q        <= K_READ;
			type_q        <= T_RSVD;
			tsel_q        <= 3'd0;
			din_q         <= 8'h00;
			msk_q         <= 8'h00;
			base_q        <= '0;
			lo_q          <= 8'h00;
			res_rd_q      <= 8'h00;
			res_ev_q      <= EV_NONE;
			res_tm_q      <= 3'd0;
			res_fv_q      <= 8'h00;
			res_fm_q      <= 8'h00;
			res_pop_q     <= 1'b0;
			wr2_en_q      <= 1'b0;
			wr2_data_q    <= 8'h00;
			out_valid_q   <= 1'b0;
			read_data_q   <= 8'h00;
			event_res_q   <= EV_NONE;
			event_timer_q <= 3'd0;
			fwd_value_q   <= 8'h00;
			fwd_mask_q    <= 8'h00;
		end else begin
			// The result is loaded in the final step and dropped once taken.
			if ((state_q == ST_WR2) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				kind_q <= kind;
				type_q <= eff_type;
				tsel_q <= timer_sel;
				din_q  <= data_in;
				msk_q  <= bit_mask;
				base_q <= base_in;
			end
			case (state_q)
				ST_CLEAR: begin
					if (clr_cnt_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						clr_cnt_q <= clr_cnt_q + CLR_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RD2;
					end
				end
				ST_RD2: begin
					lo_q    <= rf_rd;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					res_rd_q   <= x_rd;
					res_ev_q   <= x_ev;
					res_tm_q   <= x_tm;
					res_fv_q   <= x_fv;
					res_fm_q   <= x_fm;
					res_pop_q  <= x_pop;
					wr2_en_q   <= x_w2_en;
					wr2_data_q <= x_w2_data;
					state_q    <= ST_WR2;
				end
				ST_WR2: begin
					if (out_free) begin
						read_data_q   <= res_pop_q ? dm_rdata : res_rd_q;
						event_res_q   <= res_ev_q;
						event_timer_q <= res_tm_q;
						fwd_value_q   <= res_fv_q;
						fwd_mask_q    <= res_fm_q;
						state_q       <= accept ? ST_RD2 : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign event_res   = event_res_q;
	assign event_timer = event_timer_q;
	assign fwd_value   = fwd_value_q;
	assign fwd_mask    = fwd_mask_q;

	// Every accepted request starts with the second register read.
	`TIORF_ASSERT_NEXT(a_accept_to_rd2, in_valid && in_ready, state_q == ST_RD2)
	// A result appears only out of the final step.
	`TIORF_ASSERT_IMPL(a_result_from_wr2, $rose(out_valid_q), $past(state_q) == ST_WR2)
	// Nothing writes the register file while the second byte is being read.
	`TIORF_ASSERT_IMPL(a_no_write_in_rd2, state_q == ST_RD2, !rf_we)
	// Data memory is written only by the clearing pass or an in-range push.
	`TIORF_ASSERT_IMPL(a_dm_write_src, dm_we,
		(state_q == ST_CLEAR) || ((state_q == ST_EXEC) && (kind_q == K_PUSH)))

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the typed I/O register file with stack unit.
// Depends on tiorf_pkg and typed_io_register_file_with_stack_unit; drives random
// and directed register, timer and stack requests and checks every result.
module tb_top;
	import tiorf_pkg::*;

	localparam int QUIET_LIMIT = 40000;
	localparam int LONG_STALL = 150;
	localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] reg_addr;
		logic [2:0] reg_type;
		logic [2:0] timer_sel;
		logic [7:0] data_in;
		logic [7:0] bit_mask;
	} access_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [2:0] event_res;
		logic [2:0] event_timer;
		logic [7:0] fwd_value;
		logic [7:0] fwd_mask;
	} outcome_t;

	// Shadow of the register file, timer latches and data memory; it works out the
	// outcome of each accepted request and checks results against it in order.
	class access_outcome_board;
		bit [7:0] regs [REG_COUNT];
		bit [7:0] latch [TIMER_COUNT];
		bit [7:0] mem [MEM_BYTES];
		int stack_idx;
		int ram_start;
		int ram_size;
		outcome_t pending_q[$];
		int mismatches;
		int n_checked;
		int n_faults;
		int n_timer_events;

		function new();
			stack_idx = RST_STACK_IDX;
			ram_start = RST_RAM_START;
			ram_size = RST_RAM_SIZE;
		endfunction

		function void set_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
			case (idx)
				CFG_STACK_IDX: stack_idx = data[7:0];
				CFG_RAM_START: ram_start = data;
				CFG_RAM_SIZE: ram_size = data;
				default: ;
			endcase
		endfunction

		function bit [7:0] reg_at(int i);
			return (i < REG_COUNT) ? regs[i] : 8'h00;
		endfunction

		function void reg_put(int i, bit [7:0] v);
			if (i < REG_COUNT)
				regs[i] = v;
		endfunction

		function int stack_ptr();
			int sp;
			sp = reg_at(stack_idx);
			if (ram_size > SP_NARROW_MAX)
				sp = sp | (int'(reg_at(stack_idx + 1)) << 8);
			return sp;
		endfunction

		function void set_stack_ptr(int sp);
			if (ram_size > SP_NARROW_MAX)
				reg_put(stack_idx + 1, sp[15:8]);
			reg_put(stack_idx, sp[7:0]);
		endfunction

		// Plain write path; the mask only travels with eeprom and spm forwards.
		function void write_reg(int r, logic [2:0] typ, int ts, bit [7:0] val,
				bit [7:0] msk, inout outcome_t o);
			case (typ)
				T_PLAIN: regs[r] = val;
				T_CLR: regs[r] = regs[r] & ~val;
				T_EEP, T_SPM: begin
					o.event_res = (typ == T_EEP) ? EV_EEPROM : EV_SPM;
					o.fwd_value = val;
					o.fwd_mask = msk;
				end
				T_TCTRL: begin
					regs[r] = val;
					o.event_res = EV_TIMER;
					o.event_timer = 3'(ts);
				end
				T_TLOW: begin
					reg_put(r + 1, latch[ts]);
					regs[r] = val;
					o.event_res = EV_TIMER;
					o.event_timer = 3'(ts);
				end
				T_THIGH: latch[ts] = val;
				default: ;
			endcase
		endfunction

		function void apply_access(access_t a);
			outcome_t o;
			logic [2:0] typ;
			int r;
			int ts;
			int sp;
			int lim;
			int spmask;
			bit [7:0] merged;
			o = '0;
			r = a.reg_addr;
			ts = a.timer_sel;
			typ = a.reg_type;
			if (r >= REG_COUNT)
				typ = T_RSVD;
			if (typ >= T_TCTRL && ts >= TIMER_COUNT)
				typ = T_RSVD;
			lim = ram_start + ram_size;
			spmask = (ram_size > SP_NARROW_MAX) ? 'hFFFF : 'hFF;
			case (a.kind)
				K_READ: begin
					if (typ == T_RSVD)
						o.read_data = BYTE_ONES;
					else if (typ == T_THIGH)
						o.read_data = latch[ts];
					else begin
						if (typ == T_TLOW)
							latch[ts] = reg_at(r + 1);
						o.read_data = regs[r];
					end
				end
				K_WRITE: write_reg(r, typ, ts, a.data_in, BYTE_ONES, o);
				K_MASKED: begin
					if (typ == T_EEP || typ == T_SPM)
						write_reg(r, typ, ts, a.data_in, a.bit_mask, o);
					else if (typ != T_RSVD) begin
						merged = (regs[r] & ~a.bit_mask) | (a.data_in & a.bit_mask);
						write_reg(r, typ, ts, merged, BYTE_ONES, o);
					end
				end
				K_PUSH: begin
					sp = stack_ptr();
					if (sp < lim && sp < MEM_BYTES) begin
						mem[sp] = a.data_in;
						set_stack_ptr((sp - 1) & spmask);
					end else
						o.event_res = EV_FAULT;
				end
				K_POP: begin
					sp = stack_ptr();
					if (sp < lim && ((sp + 1) & spmask) < MEM_BYTES) begin
						sp = (sp + 1) & spmask;
						set_stack_ptr(sp);
						o.read_data = mem[sp];
					end else
						o.event_res = EV_FAULT;
				end
				default: ;
			endcase
			if (o.event_res == EV_FAULT)
				n_faults++;
			if (o.event_res == EV_TIMER)
				n_timer_events++;
			pending_q.push_back(o);
		endfunction

		function void field_ok(string name, logic [7:0] want, logic [7:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_outcome(outcome_t got);
			outcome_t want;
			if (pending_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				mismatches++;
				return;
			end
			want = pending_q.pop_front();
			n_checked++;
			field_ok("read_data", want.read_data, got.read_data);
			field_ok("event_res", want.event_res, got.event_res);
			field_ok("event_timer", want.event_timer, got.event_timer);
			field_ok("fwd_value", want.fwd_value, got.fwd_value);
			field_ok("fwd_mask", want.fwd_mask, got.fwd_mask);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] kind;
	logic [7:0] reg_addr;
	logic [2:0] reg_type;
	logic [2:0] timer_sel;
	logic [7:0] data_in;
	logic [7:0] bit_mask;
	logic out_valid;
	logic out_ready;
	logic [7:0] read_data;
	logic [2:0] event_res;
	logic [2:0] event_timer;
	logic [7:0] fwd_value;
	logic [7:0] fwd_mask;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [CFG_DW-1:0] cfg_data;

	access_outcome_board board = new();
	int n_access;
	int n_settings;
	int quiet;
	int burst_left;
	bit gapless;
	bit long_stall_go;

	// Settings visited after the reset phase; the sixth one is drawn at random.
	int set_idx [7] = '{0, 254, 255, 17, 128, 0, 93};
	int set_start [7] = '{0, 8192, 0, 96, 8000, 0, 256};
	int set_size [7] = '{256, 8192, 0, 257, 16383, 0, 2048};

	typed_io_register_file_with_stack_unit i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request and wait for it to be taken; bursts end in random gaps.
	task automatic send_access(logic [2:0] k, logic [7:0] ra, logic [2:0] rt,
			logic [2:0] ts, logic [7:0] d, logic [7:0] m);
		int gap;
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		reg_addr <= ra;
		reg_type <= rt;
		timer_sel <= ts;
		data_in <= d;
		bit_mask <= m;
		do
			@(posedge clk);
		while (!in_ready);
		board.apply_access({k, ra, rt, ts, d, m});
		n_access++;
		if (!gapless) begin
			if (burst_left > 0)
				burst_left--;
			else begin
				burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) :
					$urandom_range(0, 12);
				gap = $urandom_range(1, 6);
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic write_register(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		board.set_register(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop offering and wait for every outstanding result.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Addresses are drawn so that the same registers are hit again and again.
	function automatic logic [7:0] pick_addr();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 3));
			1: return 8'($urandom_range(252, 255));
			2: return 8'(board.stack_idx + $urandom_range(0, 1));
			default: return 8'($urandom);
		endcase
	endfunction

	// Random stream: stack pointer setup followed by pushes and pops, 16-bit timer
	// sequences, single register requests and a share of fully random noise.
	task automatic run_random(int count);
		int stop;
		int sel;
		int target;
		int lim;
		int ts;
		logic [7:0] r;
		stop = n_access + count;
		while (n_access < stop) begin
			sel = $urandom_range(0, 99);
			if (sel < 35) begin
				lim = board.ram_start + board.ram_size;
				case ($urandom_range(0, 3))
					0: target = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
					1: target = lim - int'($urandom_range(0, 3));
					2: target = MEM_BYTES - int'($urandom_range(0, 2));
					default: target = $urandom_range(0, 65535);
				endcase
				if (target < 0)
					target = 0;
				send_access(K_WRITE, 8'(board.stack_idx), T_PLAIN, 3'($urandom),
					target[7:0], 8'($urandom));
				if (board.stack_idx < 255)
					send_access(K_WRITE, 8'(board.stack_idx + 1), T_PLAIN, 3'($urandom),
						target[15:8], 8'($urandom));
				repeat ($urandom_range(2, 12))
					send_access($urandom_range(0, 1) ? K_PUSH : K_POP, 8'($urandom),
						3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
			end else if (sel < 55) begin
				ts = $urandom_range(0, TIMER_COUNT - 1);
				r = pick_addr();
				send_access(K_WRITE, r + 8'd1, T_THIGH, 3'(ts), 8'($urandom), 8'($urandom));
				send_access($urandom_range(0, 1) ? K_WRITE : K_MASKED, r, T_TLOW, 3'(ts),
					8'($urandom), 8'($urandom));
				if ($urandom_range(0, 2) == 0)
					send_access(K_WRITE, r + 8'd2, T_TCTRL, 3'(ts), 8'($urandom),
						8'($urandom));
				send_access(K_READ, r, T_TLOW, 3'(ts), 8'($urandom), 8'($urandom));
				send_access(K_READ, r + 8'd1, T_THIGH, 3'(ts), 8'($urandom), 8'($urandom));
			end else if (sel < 90) begin
				send_access(3'($urandom_range(0, 2)), pick_addr(), 3'($urandom),
					($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'($urandom_range(0, 5)),
					8'($urandom), 8'($urandom));
			end else begin
				send_access(3'($urandom), 8'($urandom), 3'($urandom), 3'($urandom),
					8'($urandom), 8'($urandom));
			end
		end
	endtask

	// Receiver: changing stall patterns, plus one long hold-off on request.
	initial begin
		int rx_mode;
		int rx_left;
		int rx_tick;
		rx_left = 0;
		rx_tick = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			rx_tick++;
			if (long_stall_go) begin
				out_ready <= 1'b0;
				repeat (LONG_STALL) @(negedge clk);
				long_stall_go = 1'b0;
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 3);
					rx_left = $urandom_range(8, 80);
				end
				rx_left--;
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= (rx_tick % 4 != 3);
				endcase
			end
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_outcome({read_data, event_res, event_timer, fwd_value, fwd_mask});
	end

	// Watchdog on cycles without any request or result moving.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Main sequence.
	initial begin
		int p;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = '0;
		reg_addr = '0;
		reg_type = '0;
		timer_sel = '0;
		data_in = '0;
		bit_mask = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 0;
		burst_left = 0;
		gapless = 1'b0;
		long_stall_go = 1'b0;
		n_access = 0;
		n_settings = 1;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, each register type, timer latching, stack
		// round trip, bound faults and the unused kinds.
		send_access(K_READ, 8'd0, T_PLAIN, 3'd0, 8'h00, 8'h00);
		send_access(K_WRITE, 8'd10, T_PLAIN, 3'd0, 8'hFF, 8'h00);
		send_access(K_READ, 8'd10, T_PLAIN, 3'd0, 8'h00, 8'h00);
		send_access(K_WRITE, 8'd10, T_CLR, 3'd0, 8'h0F, 8'h00);
		send_access(K_MASKED, 8'd10, T_PLAIN, 3'd0, 8'h05, 8'h0F);
		send_access(K_READ, 8'd10, T_PLAIN, 3'd0, 8'h00, 8'h00);
		send_access(K_WRITE, 8'd10, T_RSVD, 3'd0, 8'h00, 8'h00);
		send_access(K_MASKED, 8'd10, T_RSVD, 3'd0, 8'h00, 8'hFF);
		send_access(K_READ, 8'd10, T_RSVD, 3'd0, 8'h00, 8'h00);
		send_access(K_WRITE, 8'd30, T_EEP, 3'd0, 8'hA5, 8'h12);
		send_access(K_MASKED, 8'd31, T_SPM, 3'd0, 8'h3C, 8'hC3);
		send_access(K_WRITE, 8'd41, T_THIGH, 3'd5, 8'hAB, 8'h00);
		send_access(K_WRITE, 8'd40, T_TLOW, 3'd5, 8'hCD, 8'h00);
		send_access(K_READ, 8'd40, T_TLOW, 3'd2, 8'h00, 8'h00);
		send_access(K_READ, 8'd41, T_THIGH, 3'd2, 8'h00, 8'h00);
		send_access(K_WRITE, 8'd42, T_TCTRL, 3'd0, 8'h81, 8'h00);
		send_access(K_WRITE, 8'd43, T_TCTRL, 3'd6, 8'h55, 8'h00);
		send_access(K_READ, 8'd43, T_THIGH, 3'd7, 8'h00, 8'h00);
		send_access(K_WRITE, 8'd255, T_TLOW, 3'd1, 8'h77, 8'h00);
		send_access(K_READ, 8'd255, T_TLOW, 3'd1, 8'h00, 8'h00);
		send_access(K_READ, 8'd0, T_THIGH, 3'd1, 8'h00, 8'h00);
		send_access(K_WRITE, RST_STACK_IDX, T_PLAIN, 3'd0, 8'h00, 8'h00);
		send_access(K_WRITE, RST_STACK_IDX + 8'd1, T_PLAIN, 3'd0, 8'h05, 8'h00);
		send_access(K_PUSH, 8'd0, T_RSVD, 3'd0, 8'h5A, 8'h00);
		send_access(K_PUSH, 8'd0, T_RSVD, 3'd0, 8'hA5, 8'h00);
		send_access(K_POP, 8'd0, T_RSVD, 3'd0, 8'h00, 8'h00);
		send_access(K_POP, 8'd0, T_RSVD, 3'd0, 8'h00, 8'h00);
		send_access(K_WRITE, RST_STACK_IDX + 8'd1, T_PLAIN, 3'd0, 8'h09, 8'h00);
		send_access(K_PUSH, 8'd0, T_RSVD, 3'd0, 8'h11, 8'h00);
		send_access(K_POP, 8'd0, T_RSVD, 3'd0, 8'h00, 8'h00);
		send_access(3'd5, 8'hFF, T_THIGH, 3'd7, 8'hFF, 8'hFF);
		send_access(3'd7, 8'hFF, T_THIGH, 3'd7, 8'hFF, 8'hFF);

		// Back-pressure: the receiver holds off while requests keep coming.
		long_stall_go = 1'b1;
		gapless = 1'b1;
		run_random(40);
		gapless = 1'b0;
		run_random(100);
		settle();

		// Walk through the register settings, draining before each change.
		for (p = 0; p < 7; p++) begin
			if (p == 5) begin
				set_idx[p] = $urandom_range(0, 254);
				set_start[p] = $urandom_range(0, 8192);
				set_size[p] = $urandom_range(0, 8192);
			end
			write_register(CFG_RAM_SIZE, 14'(set_size[p]));
			write_register(CFG_RAM_START, 14'(set_start[p]));
			write_register(CFG_STACK_IDX, 14'(set_idx[p]));
			if (p == 6)
				write_register(CFG_UNUSED, 14'($urandom));
			n_settings++;
			run_random(135);
			settle();
		end

		$display("tb: %0d requests over %0d register settings, %0d results checked",
			n_access, n_settings, board.n_checked);
		$display("tb: %0d stack faults and %0d timer recompute events predicted",
			board.n_faults, board.n_timer_events);
		if (board.mismatches == 0 && board.pending_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
